@@ hdl/belsu_pkg.sv @@
// belsu_pkg: request/response types, codes and stage records for the
// big-endian load/store unit; no dependencies
package belsu_pkg;

	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_STORE = 1'b1;

	localparam logic [1:0] SIZE_BYTE  = 2'd0;
	localparam logic [1:0] SIZE_HALF  = 2'd1;
	localparam logic [1:0] SIZE_WORD  = 2'd2;
	localparam logic [1:0] SIZE_DWORD = 2'd3;

	typedef struct packed {
		logic               command;
		logic signed [63:0] displacement;
		logic        [63:0] base_value;
		logic        [63:0] index_value;
		logic        [7:0]  scale;
		logic        [1:0]  size_code;
		logic               zero_extend;
		logic        [63:0] store_data;
		logic               load_wanted;
	} req_t;

	typedef struct packed {
		logic [63:0] load_data;
		logic        misaligned;
	} rsp_t;

	// request with its effective address resolved
	typedef struct packed {
		logic        command;
		logic [63:0] addr;
		logic [1:0]  size_code;
		logic        zero_extend;
		logic [63:0] store_data;
		logic        load_wanted;
	} acc_t;

	// load formatting info that travels alongside the memory read
	typedef struct packed {
		logic       active;
		logic       misaligned;
		logic [2:0] shift_bytes;
		logic [1:0] size_code;
		logic       zero_extend;
	} ld_t;

endpackage

@@ hdl/belsu_agen.sv @@
// belsu_agen: input register and effective address generation
// (displacement + base + scale * index); depends on belsu_pkg
module belsu_agen (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  belsu_pkg::req_t   in_req,
	output logic              acc_valid,
	input  logic              acc_ready,
	output belsu_pkg::acc_t   acc
);
	import belsu_pkg::*;

	req_t        req_s1;
	logic        valid_s1;
	logic        valid_s2;
	logic [63:0] sum_s2;
	logic [63:0] prod_s2;
	logic        cmd_s2;
	logic [1:0]  size_s2;
	logic        zext_s2;
	logic [63:0] data_s2;
	logic        wanted_s2;
	logic        adv_s2;
	logic [63:0] sum_c;
	logic [63:0] prod_c;

	assign adv_s2   = !valid_s2 || acc_ready;
	assign in_ready = !valid_s1 || adv_s2;

	assign sum_c  = $unsigned(req_s1.displacement) + req_s1.base_value;
	assign prod_c = req_s1.index_value * {56'd0, req_s1.scale};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			req_s1 <= in_req;
		end
		if (valid_s1 && adv_s2) begin
			sum_s2    <= sum_c;
			prod_s2   <= prod_c;
			cmd_s2    <= req_s1.command;
			size_s2   <= req_s1.size_code;
			zext_s2   <= req_s1.zero_extend;
			data_s2   <= req_s1.store_data;
			wanted_s2 <= req_s1.load_wanted;
		end
	end

	assign acc_valid        = valid_s2;
	assign acc.command      = cmd_s2;
	assign acc.addr         = sum_s2 + prod_s2;
	assign acc.size_code    = size_s2;
	assign acc.zero_extend  = zext_s2;
	assign acc.store_data   = data_s2;
	assign acc.load_wanted  = wanted_s2;

endmodule

@@ hdl/belsu_mem.sv @@
// belsu_mem: word memory with byte-enable write, registered read and a
// clearing sweep after reset; no package dependency
module belsu_mem #(
	parameter int WORD_BITS = 13
) (
	input  logic                 clk,
	input  logic                 arst_n,
	output logic                 init_done,
	input  logic                 we,
	input  logic [7:0]           be,
	input  logic [WORD_BITS-1:0] waddr,
	input  logic [63:0]          wdata,
	input  logic                 re,
	input  logic [WORD_BITS-1:0] raddr,
	output logic [63:0]          rdata
);
	localparam int WORDS = 1 << WORD_BITS;

	logic [63:0]          mem [WORDS];
	logic                 clearing_q;
	logic [WORD_BITS-1:0] clr_idx_q;
	logic                 wr_en;
	logic [7:0]           wr_be;
	logic [WORD_BITS-1:0] wr_addr;
	logic [63:0]          wr_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_idx_q  <= '0;
		end else if (clearing_q) begin
			clr_idx_q <= clr_idx_q + 1'b1;
			if (&clr_idx_q) begin
				clearing_q <= 1'b0;
			end
		end
	end

	assign init_done = !clearing_q;

	assign wr_en   = clearing_q || we;
	assign wr_be   = clearing_q ? 8'hFF : be;
	assign wr_addr = clearing_q ? clr_idx_q : waddr;
	assign wr_data = clearing_q ? 64'd0 : wdata;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			for (int b = 0; b < 8; b++) begin
				if (wr_be[b]) begin
					mem[wr_addr][8*b +: 8] <= wr_data[8*b +: 8];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ hdl/big_endian_load_store_unit.sv @@
// big_endian_load_store_unit: top level of the big-endian aligned load/store
// unit; depends on belsu_pkg, belsu_agen and belsu_mem
//
// usage:
//   requests enter on req_valid/req_ready with a belsu_pkg::req_t payload,
//   responses leave on rsp_valid/rsp_ready with a belsu_pkg::rsp_t payload,
//   exactly one response per request, in request order
//   the response register is loaded after the input, address and memory read registers
//   throughput is one request per cycle unless rsp_ready stalls: input register, address add,
//   one memory port access and the response register each take one stage
//   every aligned access touches a single 64-bit word, stores use byte enables
//   reset clears the pipeline and then sweeps the memory to zero, one word a
//   cycle, 2**(ADDR_BITS-3) words (8192 at the default); req_ready stays low
//   until the sweep is done
//   a stalled receiver holds the response register; free stages behind it
//   keep filling, and req_ready drops once every stage holds a request
module big_endian_load_store_unit #(
	parameter int ADDR_BITS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  belsu_pkg::req_t   req,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output belsu_pkg::rsp_t   rsp
);
	import belsu_pkg::*;

	localparam int WORD_BITS = ADDR_BITS - 3;

	logic                 init_done;
	logic                 agen_ready;
	acc_t                 acc;
	logic                 acc_valid;
	logic                 acc_ready;
	logic                 s2_fire;
	logic [3:0]           n_bytes;
	logic [2:0]           align_mask;
	logic                 is_access;
	logic                 mis;
	logic                 go;
	logic [2:0]           sh_bytes;
	logic [7:0]           byte_mask;
	logic [7:0]           lane_be;
	logic [63:0]          lane_wdata;
	logic [WORD_BITS-1:0] widx;
	logic                 mem_we;
	logic                 mem_re;
	logic [63:0]          rdata;

	ld_t                  ld_s3;
	logic                 valid_s3;
	logic                 s3_move;
	logic [63:0]          raw;
	logic [63:0]          ext;
	rsp_t                 rsp_q;
	logic                 rsp_valid_q;

	belsu_agen u_agen (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req_valid && init_done),
		.in_ready  (agen_ready),
		.in_req    (req),
		.acc_valid (acc_valid),
		.acc_ready (acc_ready),
		.acc       (acc)
	);

	assign req_ready = agen_ready && init_done;

	// address check and lane placement
	assign n_bytes    = 4'd1 << acc.size_code;
	assign align_mask = 3'(n_bytes - 4'd1);
	assign is_access  = (acc.command == CMD_STORE) || acc.load_wanted;
	assign mis        = is_access && ((acc.addr[2:0] & align_mask) != 3'd0);
	assign go         = is_access && !mis;
	assign sh_bytes   = 3'(4'd8 - {1'b0, acc.addr[2:0]} - n_bytes);
	assign byte_mask  = 8'((9'd1 << n_bytes) - 9'd1);
	assign lane_be    = byte_mask << sh_bytes;
	assign lane_wdata = acc.store_data << {sh_bytes, 3'b000};
	assign widx       = acc.addr[ADDR_BITS-1:3];

	assign s3_move   = valid_s3 && (!rsp_valid_q || rsp_ready);
	assign acc_ready = !valid_s3 || s3_move;
	assign s2_fire   = acc_valid && acc_ready;
	assign mem_we    = s2_fire && go && (acc.command == CMD_STORE);
	assign mem_re    = s2_fire && go && (acc.command == CMD_LOAD);

	belsu_mem #(
		.WORD_BITS (WORD_BITS)
	) u_mem (
		.clk       (clk),
		.arst_n    (arst_n),
		.init_done (init_done),
		.we        (mem_we),
		.be        (lane_be),
		.waddr     (widx),
		.wdata     (lane_wdata),
		.re        (mem_re),
		.raddr     (widx),
		.rdata     (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3    <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (acc_ready) begin
				valid_s3 <= acc_valid;
			end
			if (!rsp_valid_q || rsp_ready) begin
				rsp_valid_q <= valid_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s2_fire) begin
			ld_s3.active      <= go && (acc.command == CMD_LOAD);
			ld_s3.misaligned  <= mis;
			ld_s3.shift_bytes <= sh_bytes;
			ld_s3.size_code   <= acc.size_code;
			ld_s3.zero_extend <= acc.zero_extend;
		end
	end

	// extract and extend the loaded lane
	assign raw = rdata >> {ld_s3.shift_bytes, 3'b000};

	always_comb begin
		case (ld_s3.size_code)
			SIZE_BYTE: ext = {{56{raw[7] & !ld_s3.zero_extend}}, raw[7:0]};
			SIZE_HALF: ext = {{48{raw[15] & !ld_s3.zero_extend}}, raw[15:0]};
			SIZE_WORD: ext = {{32{raw[31] & !ld_s3.zero_extend}}, raw[31:0]};
			default:   ext = raw;
		endcase
	end

	always_ff @(posedge clk) begin
		if (s3_move) begin
			rsp_q.load_data  <= ld_s3.active ? ext : 64'd0;
			rsp_q.misaligned <= ld_s3.misaligned;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

@@ hdl/belsu_chk.sv @@
// belsu_chk: port-level checks for big_endian_load_store_unit, bound to the
// top level; depends on belsu_pkg
module belsu_chk (
	input logic            clk,
	input logic            arst_n,
	input logic            req_valid,
	input logic            req_ready,
	input logic            rsp_valid,
	input logic            rsp_ready,
	input belsu_pkg::rsp_t rsp
);
	import belsu_pkg::*;

	logic [2:0] pending_q;

	// requests accepted but not yet answered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= 3'd0;
		end else begin
			pending_q <= pending_q + 3'(req_valid && req_ready)
				- 3'(rsp_valid && rsp_ready);
		end
	end

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("response changed while stalled");

	a_mis_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.misaligned |-> rsp.load_data == 64'd0)
		else $error("misaligned response carries load data");

	a_no_orphan: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> pending_q != 3'd0)
		else $error("response without a pending request");

	// every stage full and the receiver stalled
	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q == 3'd4 && !rsp_ready |-> !req_ready)
		else $error("request accepted with all stages occupied");

endmodule

bind big_endian_load_store_unit belsu_chk u_belsu_chk (.*);

@@ tb/belsu_access_checker.sv @@
// belsu_access_checker: watches the request and response channels of the big-endian
// load/store unit, predicts each response from a private memory image and compares them
// depends on belsu_pkg
module belsu_access_checker #(
	parameter int ADDR_BITS = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	input  logic            req_ready,
	input  belsu_pkg::req_t req,
	input  logic            rsp_valid,
	input  logic            rsp_ready,
	input  belsu_pkg::rsp_t rsp,
	output int              mismatches,
	output int              pending,
	output int              checked,
	output int              stores,
	output int              loads,
	output int              skipped,
	output int              misaligned_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	import belsu_pkg::*;

	localparam int WORDS = 1 << (ADDR_BITS - 3);

	logic [63:0] mem_image [0:WORDS-1];
	rsp_t        pending_rsps [$];

	function automatic rsp_t apply_access(input req_t r);
		rsp_t        res;
		logic [63:0] ea;
		logic [63:0] lane_mask;
		logic [63:0] val;
		int unsigned nbytes;
		int unsigned sh;
		res = '0;
		if (r.command == CMD_LOAD && !r.load_wanted) begin
			skipped++;
			return res;
		end
		nbytes = 1 << r.size_code;
		ea = $unsigned(r.displacement) + r.base_value + 64'(r.scale) * r.index_value;
		if ((ea & 64'(nbytes - 1)) != 64'd0) begin
			res.misaligned = 1'b1;
			misaligned_seen++;
			return res;
		end
		sh = 8 * (8 - ea[2:0] - nbytes);
		lane_mask = (nbytes == 8) ? '1 : ((64'd1 << (8 * nbytes)) - 64'd1);
		if (r.command == CMD_STORE) begin
			mem_image[ea[ADDR_BITS-1:3]] = (mem_image[ea[ADDR_BITS-1:3]] & ~(lane_mask << sh))
				| ((r.store_data & lane_mask) << sh);
			stores++;
		end else begin
			val = (mem_image[ea[ADDR_BITS-1:3]] >> sh) & lane_mask;
			if (nbytes < 8 && !r.zero_extend && val[8 * nbytes - 1])
				val |= ~lane_mask;
			res.load_data = val;
			loads++;
		end
		return res;
	endfunction

	task automatic log_mismatch(input string msg);
		mismatches++;
		if (mismatches <= 10)
			$display("%t mismatch: %s", $realtime, msg);
	endtask

	always @(posedge clk) begin
		rsp_t want;
		if (!arst_n) begin
			pending_rsps.delete();
			foreach (mem_image[i])
				mem_image[i] = '0;
			mismatches = 0;
			checked = 0;
			stores = 0;
			loads = 0;
			skipped = 0;
			misaligned_seen = 0;
		end else begin
			if (req_valid && req_ready)
				pending_rsps.push_back(apply_access(req));
			if (rsp_valid && rsp_ready) begin
				checked++;
				if (pending_rsps.size() == 0) begin
					log_mismatch($sformatf("response with none pending: load_data %h misaligned %b",
						rsp.load_data, rsp.misaligned));
				end else begin
					want = pending_rsps.pop_front();
					if (rsp.load_data !== want.load_data || rsp.misaligned !== want.misaligned)
						log_mismatch($sformatf(
							"load_data exp %h got %h, misaligned exp %b got %b",
							want.load_data, rsp.load_data, want.misaligned, rsp.misaligned));
				end
			end
		end
		pending = pending_rsps.size();
	end

endmodule

@@ tb/tb_big_endian_load_store_unit.sv @@
// tb_big_endian_load_store_unit: request stimulus, handshake pacing and verdict for the
// big-endian load/store unit; depends on belsu_pkg, belsu_access_checker and the unit itself
module tb_big_endian_load_store_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import belsu_pkg::*;

	localparam int ADDR_BITS   = 16;
	localparam int PHASE_ITEMS = 300;
	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_CYCLES = 64;

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	logic rsp_ready = 1'b0;
	req_t req       = '0;
	logic req_ready;
	logic rsp_valid;
	rsp_t rsp;

	int mismatches, pending, checked, stores, loads, skipped, misaligned_seen;
	int phase         = 0;
	int send_idle_pct = 17;
	int rsp_idle_pct  = 80;
	int cycles        = 0;

	big_endian_load_store_unit #(.ADDR_BITS(ADDR_BITS)) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp)
	);

	belsu_access_checker #(.ADDR_BITS(ADDR_BITS)) access_chk (
		.clk            (clk),
		.arst_n         (arst_n),
		.req_valid      (req_valid),
		.req_ready      (req_ready),
		.req            (req),
		.rsp_valid      (rsp_valid),
		.rsp_ready      (rsp_ready),
		.rsp            (rsp),
		.mismatches     (mismatches),
		.pending        (pending),
		.checked        (checked),
		.stores         (stores),
		.loads          (loads),
		.skipped        (skipped),
		.misaligned_seen(misaligned_seen)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	function automatic req_t plain_access(input logic cmd, input logic [1:0] size,
		input logic [63:0] addr, input logic [63:0] data, input logic zext);
		req_t r;
		r = '0;
		r.command = cmd;
		r.size_code = size;
		r.displacement = addr;
		r.store_data = data;
		r.zero_extend = zext;
		r.load_wanted = 1'b1;
		return r;
	endfunction

	// mostly lands in two small windows at the bottom and top of memory so loads hit stores
	function automatic req_t random_access();
		req_t        r;
		logic [63:0] target;
		r.command = ($urandom_range(99) < 45) ? CMD_STORE : CMD_LOAD;
		r.size_code = 2'($urandom_range(3));
		r.zero_extend = 1'($urandom_range(1));
		r.store_data = {$urandom, $urandom};
		r.load_wanted = ($urandom_range(99) < 90);
		r.base_value = {$urandom, $urandom};
		r.index_value = {$urandom, $urandom};
		case ($urandom_range(3))
			0: r.scale = 8'd0;
			1: r.scale = 8'd1;
			default: r.scale = 8'($urandom);
		endcase
		r.displacement = {$urandom, $urandom};
		if ($urandom_range(99) < 8)
			return r;
		target = {$urandom, $urandom};
		if ($urandom_range(1))
			target[63:16] = '0;
		target[15:0] = $urandom_range(1) ? 16'($urandom_range(511))
			: 16'hFE00 + 16'($urandom_range(511));
		if ($urandom_range(99) < 90)
			target = target & ~64'((1 << r.size_code) - 1);
		r.displacement = target - r.base_value - 64'(r.scale) * r.index_value;
		return r;
	endfunction

	task automatic send_request(input req_t r);
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req <= r;
		req_valid <= 1'b1;
		do
			@(posedge clk);
		while (!req_ready);
		@(negedge clk);
	endtask

	// receiver pacing, with one long hold-off once the sender stops idling
	initial begin : rsp_side
		int hold_count;
		hold_count = 0;
		forever begin
			@(negedge clk);
			if (phase == 2 && hold_count < HOLD_CYCLES) begin
				rsp_ready <= 1'b0;
				hold_count++;
			end else begin
				rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
			end
		end
	end

	initial begin : stimulus
		req_t r;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_request(plain_access(CMD_STORE, SIZE_DWORD, 64'd0, 64'h0123_4567_89AB_CDEF, 1'b0));
		send_request(plain_access(CMD_LOAD, SIZE_DWORD, 64'd0, '0, 1'b1));
		send_request(plain_access(CMD_LOAD, SIZE_BYTE, 64'd0, '0, 1'b0));
		send_request(plain_access(CMD_LOAD, SIZE_BYTE, 64'd7, '0, 1'b0));
		send_request(plain_access(CMD_LOAD, SIZE_BYTE, 64'd7, '0, 1'b1));
		send_request(plain_access(CMD_LOAD, SIZE_HALF, 64'd6, '0, 1'b0));
		send_request(plain_access(CMD_LOAD, SIZE_WORD, 64'd4, '0, 1'b0));
		send_request(plain_access(CMD_LOAD, SIZE_WORD, 64'd4, '0, 1'b1));
		r = plain_access(CMD_STORE, SIZE_BYTE, 64'd8, 64'hFFFF_FFFF_FFFF_FF80, 1'b0);
		r.load_wanted = 1'b0;
		send_request(r);
		send_request(plain_access(CMD_STORE, SIZE_HALF, 64'd10, 64'h0000_0000_0000_8001, 1'b0));
		send_request(plain_access(CMD_STORE, SIZE_WORD, 64'd12, 64'hDEAD_BEEF_F00D_CAFE, 1'b0));
		send_request(plain_access(CMD_LOAD, SIZE_DWORD, 64'd8, '0, 1'b0));
		// misaligned accesses leave memory alone
		send_request(plain_access(CMD_LOAD, SIZE_HALF, 64'd1, '0, 1'b0));
		send_request(plain_access(CMD_STORE, SIZE_WORD, 64'd2, '1, 1'b0));
		send_request(plain_access(CMD_STORE, SIZE_DWORD, 64'd4, '1, 1'b0));
		send_request(plain_access(CMD_LOAD, SIZE_DWORD, 64'd0, '0, 1'b0));
		r = plain_access(CMD_LOAD, SIZE_DWORD, 64'd3, '0, 1'b0);
		r.load_wanted = 1'b0;
		send_request(r);
		// address wraps modulo 2**64 and above the memory size
		r = plain_access(CMD_LOAD, SIZE_DWORD, 64'h7FFF_FFFF_FFFF_FFFF, '0, 1'b0);
		r.base_value = 64'h8000_0000_0000_0001;
		send_request(r);
		r = plain_access(CMD_LOAD, SIZE_BYTE, 64'h8000_0000_0000_0000, '0, 1'b1);
		r.index_value = '1;
		r.scale = 8'hFF;
		send_request(r);
		send_request(plain_access(CMD_STORE, SIZE_DWORD, 64'h1234_5678_9ABC_FFF8, '1, 1'b0));
		send_request(plain_access(CMD_LOAD, SIZE_BYTE, 64'hFFFF, '0, 1'b0));
		send_request(plain_access(CMD_LOAD, SIZE_WORD, 64'hFFFF_FFFF_FFFF_FFFC, '0, 1'b1));

		for (int p = 0; p < 3; p++) begin
			phase = p;
			send_idle_pct = (p == 0) ? 17 : (p == 1) ? 80 : 0;
			rsp_idle_pct  = (p == 0) ? 80 : (p == 1) ? 17 : 0;
			repeat (PHASE_ITEMS)
				send_request(random_access());
		end
		req_valid <= 1'b0;

		while (pending != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);

		$display("checked %0d responses: %0d stores, %0d loads, %0d skipped loads, %0d misaligned",
			checked, stores, loads, skipped, misaligned_seen);
		$display("pacing: slow receiver, slow sender, full rate with a %0d-cycle receiver stall",
			HOLD_CYCLES);
		if (mismatches == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
